>>> rtl/frame_header_checker_top_defines.svh
// Assertion helpers shared by the checker's RTL files.
`ifndef FRAME_HEADER_CHECKER_TOP_DEFINES_SVH
`define FRAME_HEADER_CHECKER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define FHC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FHC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fhc_pkg.sv
`default_nettype none

package fhc_pkg;

  // Header layout, byte offsets.
  localparam logic [5:0] POS_VERSION = 6'd4;
  localparam logic [5:0] POS_TYPE    = 6'd6;
  localparam logic [5:0] POS_FLAGS   = 6'd8;
  localparam logic [5:0] POS_LENGTH  = 6'd12;
  localparam logic [5:0] POS_SEQ     = 6'd16;
  localparam logic [5:0] POS_CORR    = 6'd24;
  localparam logic [5:0] POS_PCRC    = 6'd32;
  localparam logic [5:0] POS_HCRC    = 6'd36;
  localparam logic [5:0] POS_LAST    = 6'd39;

  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

  // Register map, word index (paddr[4:2]).
  localparam logic [2:0] REG_MAGIC    = 3'd0;
  localparam logic [2:0] REG_VERSION  = 3'd1;
  localparam logic [2:0] REG_TYPES    = 3'd2;
  localparam logic [2:0] REG_CEILING  = 3'd3;
  localparam logic [2:0] REG_LIMIT    = 3'd4;

  localparam logic [31:0] RST_MAGIC   = 32'h0000_0000;
  localparam logic [15:0] RST_VERSION = 16'd1;
  localparam logic [15:0] RST_TYPES   = 16'd46;
  localparam logic [31:0] RST_CEILING = 32'h0100_0000;
  localparam logic [31:0] RST_LIMIT   = 32'h0100_0000;

  localparam int TDATA_W = 216;

  typedef enum logic [3:0] {
    VERDICT_OK      = 4'd0,
    VERDICT_TRUNC   = 4'd1,
    VERDICT_MAGIC   = 4'd2,
    VERDICT_VERSION = 4'd3,
    VERDICT_TYPE    = 4'd4,
    VERDICT_HCRC    = 4'd5,
    VERDICT_CEILING = 4'd6,
    VERDICT_LIMIT   = 4'd7,
    VERDICT_FLAGS   = 4'd8
  } verdict_t;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [15:0] expected_version;
    logic [15:0] type_count;
    logic [31:0] absolute_ceiling;
    logic [31:0] negotiated_limit;
  } cfg_t;

  // One finished (or cut-short) header, handed from front to back.
  typedef struct packed {
    logic        truncated;
    logic        magic_ok;
    logic        crc_ok;
    logic        flags_nz;
    logic [15:0] version;
    logic [15:0] msg_type;
    logic [31:0] length;
    logic [63:0] sequence_num;
    logic [63:0] correlation;
    logic [31:0] payload_crc;
  } hdr_rec_t;

  // Reflected CRC-32C, one byte.
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc_in,
                                              input logic [7:0]  b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/frame_header_checker_top.sv
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata[7:0] data_byte, s_tlast end_of_span
// m_*       out  m_tvalid/m_tready  m_tdata verdict, type, length, seq, corr, crc
// APB       in   psel/penable       paddr, pwdata, prdata; pready tied high
//
// One header byte per cycle is accepted while the record queue is not full;
// the bytewise CRC-32C update in the front sets that figure. After its last
// byte, a verdict beat passes a queue slot, then the output register. Input
// stalls only when the record queue is full, i.e. once QUEUE_DEPTH + 1 verdicts
// (queue plus output register) wait on m_tready. Reset is synchronous, clears
// all control state and restores register defaults; no memory sweep is needed.

module frame_header_checker_top
  import fhc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2  // header records between front and back, 2..16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // header byte stream
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [7:0]          s_tdata,   // [7:0] data_byte
  input  wire logic                s_tlast,   // end_of_span
  // verdict stream
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic       [TDATA_W-1:0] m_tdata,   // [3:0] verdict, [19:4] message_type,
                                              // [51:20] body length in bytes,
                                              // [115:52] sequence_number,
                                              // [179:116] correlation_id,
                                              // [211:180] payload_checksum,
                                              // [215:212] zero
  // register port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready
);

  cfg_t     cfg;
  hdr_rec_t push_rec;
  hdr_rec_t head_rec;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_valid;

  assign pready = 1'b1;

  // Static settings; user must write only while no header is in flight; unchecked.
  fhc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Front: byte position, CRC, field capture. Emits one record per header,
  // either complete at byte 40 or marked truncated on an early tlast.
  fhc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_byte    (s_tdata),
    .in_last    (s_tlast),
    .q_full     (q_full),
    .magic_word (cfg.magic_word),
    .in_ready   (s_tready),
    .push       (push),
    .rec        (push_rec)
  );

  // Decouples byte intake from verdict back-pressure.
  fhc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (push_rec),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head_rec)
  );

  // Back: priority checks against the settings, then the output register.
  fhc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_rec    (head_rec),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

>>> rtl/fhc_regs.sv
`default_nettype none

module fhc_regs
  import fhc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output cfg_t             cfg
);

  logic wr_en;
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_word       <= RST_MAGIC;
      cfg.expected_version <= RST_VERSION;
      cfg.type_count       <= RST_TYPES;
      cfg.absolute_ceiling <= RST_CEILING;
      cfg.negotiated_limit <= RST_LIMIT;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_MAGIC:   cfg.magic_word       <= pwdata;
        REG_VERSION: cfg.expected_version <= pwdata[15:0];
        REG_TYPES:   cfg.type_count       <= pwdata[15:0];
        REG_CEILING: cfg.absolute_ceiling <= pwdata;
        REG_LIMIT:   cfg.negotiated_limit <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_MAGIC:   prdata = cfg.magic_word;
      REG_VERSION: prdata = {16'd0, cfg.expected_version};
      REG_TYPES:   prdata = {16'd0, cfg.type_count};
      REG_CEILING: prdata = cfg.absolute_ceiling;
      REG_LIMIT:   prdata = cfg.negotiated_limit;
      default:     prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/fhc_front.sv
`default_nettype none

module fhc_front
  import fhc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  input  wire logic       q_full,
  input  wire logic [31:0] magic_word,
  output logic            in_ready,
  output logic            push,
  output hdr_rec_t        rec
);

  `include "frame_header_checker_top_defines.svh"

  logic [5:0]  pos;
  logic [31:0] crc;
  logic        magic_ok;
  logic        flags_nz;
  logic        given;

  logic [15:0] version;
  logic [15:0] msg_type;
  logic [31:0] length;
  logic [63:0] sequence_num;
  logic [63:0] correlation;
  logic [31:0] payload_crc;
  logic [23:0] hdr_crc;

  logic accept;
  logic at_end;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign at_end   = (pos == POS_LAST);
  assign push     = accept && !given && (at_end || in_last);

  always_comb begin
    rec.truncated    = !at_end;
    rec.magic_ok     = magic_ok;
    rec.crc_ok       = ((crc ^ 32'hFFFF_FFFF) == {in_byte, hdr_crc});
    rec.flags_nz     = flags_nz;
    rec.version      = version;
    rec.msg_type     = msg_type;
    rec.length       = length;
    rec.sequence_num = sequence_num;
    rec.correlation  = correlation;
    rec.payload_crc  = payload_crc;
  end

  // Control state: position, running CRC, sticky flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      crc      <= 32'hFFFF_FFFF;
      magic_ok <= 1'b1;
      flags_nz <= 1'b0;
      given    <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        // end of span: re-arm for the next header
        pos      <= '0;
        crc      <= 32'hFFFF_FFFF;
        magic_ok <= 1'b1;
        flags_nz <= 1'b0;
        given    <= 1'b0;
      end else if (!given) begin
        if (pos < POS_HCRC) crc <= crc32c_byte(crc, in_byte);
        if (pos < POS_VERSION && in_byte != magic_word[{pos[1:0], 3'b000} +: 8])
          magic_ok <= 1'b0;
        if (pos >= POS_FLAGS && pos < POS_LENGTH && in_byte != 8'd0)
          flags_nz <= 1'b1;
        if (at_end) given <= 1'b1;
        else        pos   <= pos + 6'd1;
      end
    end
  end

  // Field capture; lanes written at most once a header, no clearing.
  always_ff @(posedge clk) begin
    if (accept && !given) begin
      if (pos >= POS_VERSION && pos < POS_TYPE)
        version[{pos[0], 3'b000} +: 8] <= in_byte;
      if (pos >= POS_TYPE && pos < POS_FLAGS)
        msg_type[{pos[0], 3'b000} +: 8] <= in_byte;
      if (pos >= POS_LENGTH && pos < POS_SEQ)
        length[{pos[1:0], 3'b000} +: 8] <= in_byte;
      if (pos >= POS_SEQ && pos < POS_CORR)
        sequence_num[{pos[2:0], 3'b000} +: 8] <= in_byte;
      if (pos >= POS_CORR && pos < POS_PCRC)
        correlation[{pos[2:0], 3'b000} +: 8] <= in_byte;
      if (pos >= POS_PCRC && pos < POS_HCRC)
        payload_crc[{pos[1:0], 3'b000} +: 8] <= in_byte;
      if (pos >= POS_HCRC && pos < POS_LAST)
        hdr_crc[{pos[1:0], 3'b000} +: 8] <= in_byte;
    end
  end

  `FHC_ASSERT_NOW(a_given_at_end, clk, rst, given, pos == POS_LAST,
                  "verdict flag set away from the last header byte")

endmodule

`default_nettype wire

>>> rtl/fhc_queue.sv
`default_nettype none

module fhc_queue
  import fhc_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire hdr_rec_t push_rec,
  input  wire logic     pop,
  output logic          full,
  output logic          not_empty,
  output hdr_rec_t      head
);

  `include "frame_header_checker_top_defines.svh"

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_TOP = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W-1:0] PTR_ONE = PTR_W'(1);
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  hdr_rec_t         slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_TOP);
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_TOP) ? '0 : wr_ptr + PTR_ONE;
      if (pop)  rd_ptr <= (rd_ptr == PTR_TOP) ? '0 : rd_ptr + PTR_ONE;
      if (push && !pop)      count <= count + CNT_ONE;
      else if (pop && !push) count <= count - CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_rec;
  end

  `FHC_ASSERT_NOW(a_no_push_full, clk, rst, push, !full,
                  "header record pushed into a full queue")
  `FHC_ASSERT_NOW(a_no_pop_empty, clk, rst, pop, not_empty,
                  "header record popped from an empty queue")

endmodule

`default_nettype wire

>>> rtl/fhc_back.sv
`default_nettype none

module fhc_back
  import fhc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cfg_t                cfg,
  input  wire logic                q_valid,
  input  wire hdr_rec_t            q_rec,
  output logic                     pop,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic       [TDATA_W-1:0] m_tdata
);

  `include "frame_header_checker_top_defines.svh"

  verdict_t     verdict;
  logic [211:0] beat;

  assign pop = q_valid && (!m_tvalid || m_tready);

  // Checks in priority order.
  always_comb begin
    if (q_rec.truncated)                                verdict = VERDICT_TRUNC;
    else if (!q_rec.magic_ok)                           verdict = VERDICT_MAGIC;
    else if (q_rec.version != cfg.expected_version)     verdict = VERDICT_VERSION;
    else if (q_rec.msg_type == 16'd0 || q_rec.msg_type >= cfg.type_count)
                                                        verdict = VERDICT_TYPE;
    else if (!q_rec.crc_ok)                             verdict = VERDICT_HCRC;
    else if (q_rec.length > cfg.absolute_ceiling)       verdict = VERDICT_CEILING;
    else if (q_rec.length > cfg.negotiated_limit)       verdict = VERDICT_LIMIT;
    else if (q_rec.flags_nz)                            verdict = VERDICT_FLAGS;
    else                                                verdict = VERDICT_OK;
  end

  always_comb begin
    if (verdict == VERDICT_OK) begin
      beat = {q_rec.payload_crc, q_rec.correlation, q_rec.sequence_num,
              q_rec.length, q_rec.msg_type, verdict};
    end else begin
      beat = {208'd0, verdict};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) m_tdata <= {4'd0, beat};
  end

  `FHC_ASSERT_NEXT(a_pop_to_out, clk, rst, pop, m_tvalid,
                   "popped record did not reach the output register")
  `FHC_ASSERT_NOW(a_fail_zero, clk, rst,
                  m_tvalid && (m_tdata[3:0] != VERDICT_OK),
                  m_tdata[TDATA_W-1:4] == '0,
                  "failed verdict carries nonzero fields")

endmodule

`default_nettype wire
